// File: design/vud_pkg.sv
`default_nettype none
package vud_pkg;

	// number of samples averaged into the baseline (default)
	localparam int CALIB_SAMPLES_DEF = 16;

	// sample, axis and counter widths
	localparam int SMP_W   = 16;
	localparam int MAG_W   = 15;
	localparam int SUM_W   = 20;
	localparam int HIT_W   = 8;
	localparam int HSUM_W  = 10;
	localparam int THR_W   = 16;
	localparam int CMP_W   = 18;
	localparam int BASE_SH = 4;
	localparam int NAXIS   = 3;

	// max tracker reset value, -32000
	localparam logic signed [SMP_W-1:0] MAX_RESET = -16'sd32000;
	localparam logic [SUM_W-1:0]        SUM_CAP   = '1;
	localparam logic [MAG_W-1:0]        MAG_CAP   = '1;

	// APB register file
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_FLAG   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_X_THR   = 3'd0,
		REG_Y_THR   = 3'd1,
		REG_Z_THR   = 3'd2,
		REG_HIT_LIM = 3'd3,
		REG_CRIT_LIM = 3'd4,
		REG_DET_EN  = 3'd5
	} reg_idx_t;

	// absolute value with -32768 clipped to 32767
	function automatic logic [MAG_W-1:0] abs_sat(input logic signed [SMP_W-1:0] v);
		logic [SMP_W-1:0] mag;
		mag = v[SMP_W-1] ? (~v + 1'b1) : v;
		return mag[SMP_W-1] ? MAG_CAP : mag[MAG_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/vud_item_if.sv
`default_nettype none
interface vud_item_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic signed [15:0]  x_sample;
	logic signed [15:0]  y_sample;
	logic signed [15:0]  z_sample;
	logic                flag_value;

	modport source (output valid, func, x_sample, y_sample, z_sample, flag_value,
		input ready);
	modport sink (input valid, func, x_sample, y_sample, z_sample, flag_value,
		output ready);
endinterface
`default_nettype wire

// File: design/vud_result_if.sv
`default_nettype none
interface vud_result_if;
	logic                valid;
	logic                ready;
	logic                unbalance;
	logic                calibrated;
	logic [9:0]          sum_hits;
	logic [7:0]          critical_hits;
	logic signed [15:0]  max_x;
	logic signed [15:0]  max_y;
	logic signed [15:0]  max_z;
	logic [14:0]         base_x;
	logic [14:0]         base_y;
	logic [14:0]         base_z;

	modport source (output valid, unbalance, calibrated, sum_hits, critical_hits,
		max_x, max_y, max_z, base_x, base_y, base_z, input ready);
	modport sink (input valid, unbalance, calibrated, sum_hits, critical_hits,
		max_x, max_y, max_z, base_x, base_y, base_z, output ready);
endinterface
`default_nettype wire

// File: design/vibration_unbalance_detector_core.sv
`default_nettype none
// Vibration unbalance detector. Each transaction on the item channel carries a
// command (func): a three-axis accelerometer sample, a direct write of the
// unbalance flag, or a clear of the hit counters; every transaction yields
// exactly one result transaction with the flag, calibration status, hit sums,
// per-axis maxima and baselines as they stand after that command. The first
// CALIB_SAMPLES samples (2..256) only build the per-axis baseline (sum >> 4,
// clipped to 32767); from then on samples update the maxima and the hit /
// critical counters, and the flag rises once the critical count reaches
// critical_limit while detect_enable is set. Throughput is one transaction per
// clock while results are taken: the item is captured in an input register,
// all state and the result are computed in one short pass and land in the
// state and result registers once the result register is free or emptied.
// The result register lets a new item enter while a finished result waits.
// Thresholds and limits sit in an APB register file (x_threshold at 0x00,
// y_threshold 0x04, z_threshold 0x08, hit_limit 0x0C, critical_limit 0x10,
// detect_enable 0x14); write them only while the block is idle.
module vibration_unbalance_detector_core #(
	parameter int CALIB_SAMPLES = vud_pkg::CALIB_SAMPLES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	vud_item_if.sink                          item,
	vud_result_if.source                      result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vud_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [vud_pkg::PDATA_W-1:0]  pwdata,
	output logic      [vud_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import vud_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(CALIB_SAMPLES);

	// ---------------- configuration registers ----------------
	logic signed [THR_W-1:0] thr_q [NAXIS];
	logic [HIT_W-1:0]        hit_limit_q;
	logic [HIT_W-1:0]        crit_limit_q;
	logic                    detect_en_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXIS; i++) thr_q[i] <= '0;
			hit_limit_q  <= '0;
			crit_limit_q <= '0;
			detect_en_q  <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_X_THR:    thr_q[0]     <= pwdata[THR_W-1:0];
				REG_Y_THR:    thr_q[1]     <= pwdata[THR_W-1:0];
				REG_Z_THR:    thr_q[2]     <= pwdata[THR_W-1:0];
				REG_HIT_LIM:  hit_limit_q  <= pwdata[HIT_W-1:0];
				REG_CRIT_LIM: crit_limit_q <= pwdata[HIT_W-1:0];
				REG_DET_EN:   detect_en_q  <= pwdata[0];
				default: ;  // unmapped address, drop the write
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_X_THR:    prdata = {{(PDATA_W-THR_W){1'b0}}, thr_q[0]};
			REG_Y_THR:    prdata = {{(PDATA_W-THR_W){1'b0}}, thr_q[1]};
			REG_Z_THR:    prdata = {{(PDATA_W-THR_W){1'b0}}, thr_q[2]};
			REG_HIT_LIM:  prdata = {{(PDATA_W-HIT_W){1'b0}}, hit_limit_q};
			REG_CRIT_LIM: prdata = {{(PDATA_W-HIT_W){1'b0}}, crit_limit_q};
			REG_DET_EN:   prdata = {{(PDATA_W-1){1'b0}}, detect_en_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic                    valid_s1;
	func_t                   func_s1;
	logic [MAG_W-1:0]        mag_s1 [NAXIS];
	logic                    flag_value_s1;
	logic                    result_valid_q;
	logic                    advance;

	// advance the item whenever the result register is free or being emptied
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			func_s1  <= FUNC_NOP;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
			if (item.valid) func_s1 <= func_t'(item.func);
		end
	end

	// magnitudes are taken on the way in; raw samples are never needed again
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mag_s1[0]     <= abs_sat(item.x_sample);
			mag_s1[1]     <= abs_sat(item.y_sample);
			mag_s1[2]     <= abs_sat(item.z_sample);
			flag_value_s1 <= item.flag_value;
		end
	end

	// ---------------- detector state ----------------
	logic [SUM_W-1:0]        calib_sum_q [NAXIS];  // partial sums, then baselines
	logic [CNT_W-1:0]        calib_cnt_q;
	logic [MAG_W-1:0]        peak_q [NAXIS];
	logic signed [SMP_W-1:0] max_q [NAXIS];
	logic [HIT_W-1:0]        hits_q [NAXIS];
	logic [HIT_W-1:0]        crit_q;
	logic                    armed_q;
	logic                    flag_q;

	logic [SUM_W-1:0]        calib_sum_n [NAXIS];
	logic [CNT_W-1:0]        calib_cnt_n;
	logic [MAG_W-1:0]        peak_n [NAXIS];
	logic signed [SMP_W-1:0] max_n [NAXIS];
	logic [HIT_W-1:0]        hits_n [NAXIS];
	logic [HIT_W-1:0]        crit_n;
	logic                    armed_n;
	logic                    flag_n;

	logic                    cal_now;
	logic                    cal_n;
	logic [SUM_W:0]          acc [NAXIS];
	logic [SUM_W-1:0]        acc_sat [NAXIS];
	logic [SUM_W-1:0]        base_raw [NAXIS];
	logic signed [CMP_W-1:0] lim [NAXIS];
	logic                    over [NAXIS];
	logic                    any_over;
	logic                    taken;
	logic [HSUM_W-1:0]       hsum_n;

	assign cal_now = (calib_cnt_q == CNT_DONE);

	// per-axis terms, independent of each other
	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			acc[i]      = {1'b0, calib_sum_q[i]} + (SUM_W+1)'(mag_s1[i]);
			acc_sat[i]  = acc[i][SUM_W] ? SUM_CAP : acc[i][SUM_W-1:0];
			base_raw[i] = acc_sat[i] >> BASE_SH;
			lim[i]      = $signed({{(CMP_W-MAG_W){1'b0}}, calib_sum_q[i][MAG_W-1:0]})
				+ CMP_W'(thr_q[i]);
			over[i]     = $signed({{(CMP_W-MAG_W){1'b0}}, mag_s1[i]}) > lim[i];
		end
		any_over = over[0] || over[1] || over[2];
	end

	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			calib_sum_n[i] = calib_sum_q[i];
			peak_n[i]      = peak_q[i];
			max_n[i]       = max_q[i];
			hits_n[i]      = hits_q[i];
		end
		calib_cnt_n = calib_cnt_q;
		crit_n      = crit_q;
		armed_n     = armed_q;
		flag_n      = flag_q;
		taken       = 1'b0;
		hsum_n      = '0;

		unique case (func_s1)
			FUNC_SAMPLE: begin
				if (!cal_now) begin
					// accumulate; on the last sample turn the sums into baselines
					calib_cnt_n = calib_cnt_q + 1'b1;
					for (int i = 0; i < NAXIS; i++) begin
						calib_sum_n[i] = acc_sat[i];
						if (calib_cnt_n == CNT_DONE) begin
							calib_sum_n[i] = (base_raw[i] > SUM_W'(MAG_CAP)) ?
								SUM_W'(MAG_CAP) : base_raw[i];
							peak_n[i] = calib_sum_n[i][MAG_W-1:0];
						end
					end
				end else begin
					for (int i = 0; i < NAXIS; i++) begin
						if ($signed({1'b0, mag_s1[i]}) > max_q[i]) begin
							max_n[i] = {1'b0, mag_s1[i]};
						end
					end
					if (any_over && armed_q) begin
						crit_n = crit_q + 1'b1;
						if (crit_n >= crit_limit_q && detect_en_q) begin
							for (int i = 0; i < NAXIS; i++) hits_n[i] = '0;
							crit_n  = '0;
							flag_n  = 1'b1;
							armed_n = 1'b0;
						end
					end else begin
						// first axis in x, y, z order that scores takes the hit
						for (int i = 0; i < NAXIS; i++) begin
							if (!taken) begin
								if (mag_s1[i] > peak_q[i]) begin
									peak_n[i] = mag_s1[i];
									hits_n[i] = hits_q[i] + 1'b1;
									taken     = 1'b1;
								end else if (over[i]) begin
									hits_n[i] = hits_q[i] + HIT_W'(2);
									taken     = 1'b1;
								end
							end
						end
					end
					hsum_n = HSUM_W'(hits_n[0]) + HSUM_W'(hits_n[1]) + HSUM_W'(hits_n[2]);
					if (hsum_n > HSUM_W'(hit_limit_q)) armed_n = 1'b1;
				end
			end
			FUNC_FLAG: begin
				flag_n = flag_value_s1;
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < NAXIS; i++) begin
					hits_n[i] = '0;
					peak_n[i] = cal_now ? calib_sum_q[i][MAG_W-1:0] : '0;
				end
				crit_n  = '0;
				armed_n = 1'b0;
			end
			FUNC_NOP: ;
		endcase
		cal_n = (calib_cnt_n == CNT_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXIS; i++) begin
				calib_sum_q[i] <= '0;
				peak_q[i]      <= '0;
				max_q[i]       <= MAX_RESET;
				hits_q[i]      <= '0;
			end
			calib_cnt_q <= '0;
			crit_q      <= '0;
			armed_q     <= 1'b0;
			flag_q      <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < NAXIS; i++) begin
				calib_sum_q[i] <= calib_sum_n[i];
				peak_q[i]      <= peak_n[i];
				max_q[i]       <= max_n[i];
				hits_q[i]      <= hits_n[i];
			end
			calib_cnt_q <= calib_cnt_n;
			crit_q      <= crit_n;
			armed_q     <= armed_n;
			flag_q      <= flag_n;
		end
	end

	// ---------------- result register ----------------
	logic                    unbalance_q;
	logic                    calibrated_q;
	logic [HSUM_W-1:0]       sum_hits_q;
	logic [HIT_W-1:0]        crit_out_q;
	logic signed [SMP_W-1:0] max_out_q [NAXIS];
	logic [MAG_W-1:0]        base_out_q [NAXIS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			unbalance_q  <= flag_n;
			calibrated_q <= cal_n;
			sum_hits_q   <= HSUM_W'(hits_n[0]) + HSUM_W'(hits_n[1]) + HSUM_W'(hits_n[2]);
			crit_out_q   <= crit_n;
			for (int i = 0; i < NAXIS; i++) begin
				max_out_q[i]  <= max_n[i];
				base_out_q[i] <= cal_n ? calib_sum_n[i][MAG_W-1:0] : '0;
			end
		end
	end

	assign result.valid         = result_valid_q;
	assign result.unbalance     = unbalance_q;
	assign result.calibrated    = calibrated_q;
	assign result.sum_hits      = sum_hits_q;
	assign result.critical_hits = crit_out_q;
	assign result.max_x         = max_out_q[0];
	assign result.max_y         = max_out_q[1];
	assign result.max_z         = max_out_q[2];
	assign result.base_x        = base_out_q[0];
	assign result.base_y        = base_out_q[1];
	assign result.base_z        = base_out_q[2];

	// ---------------- checks ----------------
	// calibration counter stops at the sample count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		calib_cnt_q <= CNT_DONE)
		else $error("calibration count past its end");

	// once calibrated, the block stays calibrated
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_now |=> cal_now)
		else $error("calibration lost");

	// the input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && result_valid_q && !result.ready))
		else $error("input stalled without a waiting result");

	// the flag rises only from a sample or a flag write
	a_flag_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> $past(advance && (func_s1 == FUNC_SAMPLE || func_s1 == FUNC_FLAG)))
		else $error("unbalance flag rose without a cause");

endmodule
`default_nettype wire
